/* sv/escape_unescaper_utf8_validator_unit_assert.svh */
// Assertion macros used by the checker file of the escape decoder.
`ifndef ESCAPE_UNESCAPER_UTF8_VALIDATOR_UNIT_ASSERT_SVH
`define ESCAPE_UNESCAPER_UTF8_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EUV_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("escape decoder assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define EUV_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("escape decoder assertion failed");

`endif

/* sv/esc_utf8_pkg.sv */
// Types, codes, constants and helper functions of the escape decoder.
package esc_utf8_pkg;

    // Default width of the code point counter.
    localparam int DEFAULT_COUNT_WIDTH = 32;

    // Decoder mode.
    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESC,
        M_HEX_X,
        M_HEX_U4,
        M_HEX_U8
    } t_mode;

    // Error codes, sticky until the end of the string.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
    localparam logic [2:0] ERR_TRUNC_HEX = 3'd2;
    localparam logic [2:0] ERR_BAD_UNI   = 3'd3;
    localparam logic [2:0] ERR_CP_RANGE  = 3'd4;
    localparam logic [2:0] ERR_BAD_START = 3'd5;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd6;

    // Character kinds.
    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_TWO   = 2'd1;
    localparam logic [1:0] KIND_THREE = 2'd2;
    localparam logic [1:0] KIND_FOUR  = 2'd3;

    // Source characters with a meaning after a backslash.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    // Control bytes produced by the simple escapes.
    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;

    // Largest code point plus one.
    localparam logic [31:0] CP_LIMIT = 32'h0011_0000;

    // Value of a hex digit; bit 4 set marks a character that is no hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // Simple escape lookup: bit 8 set when the character names a fixed byte.
    function automatic logic [8:0] esc_control(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_LOW_A:  r = {1'b1, CTL_BEL};
            CH_LOW_B:  r = {1'b1, CTL_BS};
            CH_LOW_F:  r = {1'b1, CTL_FF};
            CH_LOW_N:  r = {1'b1, CTL_LF};
            CH_LOW_R:  r = {1'b1, CTL_CR};
            CH_LOW_T:  r = {1'b1, CTL_HT};
            CH_LOW_V:  r = {1'b1, CTL_VT};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            default:   r = 9'h000;
        endcase
        return r;
    endfunction

endpackage

/* sv/escape_unescaper_utf8_validator_unit.sv */
// Top level of the backslash escape decoder with UTF-8 checking.
//
// The block takes one source byte per beat and decodes backslash escapes
// (simple control escapes, \xhh, \uhhhh and \Uhhhhhhhh) while checking raw
// bytes as UTF-8. A source byte is taken into an input register, decoded
// combinationally into a registered result group of up to four bytes, and the
// group is handed out one result beat per cycle while the receiver is ready.
// A new source byte can be taken every cycle while the receiver is ready, so
// one byte per cycle is sustained whenever each byte yields at most one result;
// a byte that yields k results holds the output until all k are taken (k is at
// most four, the longest UTF-8 sequence). The final byte of a string always ends
// with a result that has string_done set, and all decoder state then returns to its reset value.
module escape_unescaper_utf8_validator_unit #(
    parameter int COUNT_WIDTH = esc_utf8_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_end,
    output logic        o_string_done,
    output logic [2:0]  o_error_code,
    output logic [1:0]  o_char_kind,
    output logic [31:0] o_char_count
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state.
    esc_utf8_pkg::t_mode    r_mode, n_mode;
    logic [3:0]             r_digits, n_digits;
    logic [31:0]            r_acc, n_acc;
    logic [1:0]             r_utf8, n_utf8;
    logic [1:0]             r_kind, n_kind;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [2:0]             r_err, n_err;

    // Result group register.
    logic        r_busy;
    logic [1:0]  r_ptr;
    logic [2:0]  r_num;
    logic        r_has_bytes;
    logic        r_last;
    logic [7:0]  r_bytes [4];
    logic [2:0]  r_res_err;
    logic [1:0]  r_res_kind;
    logic [31:0] r_res_count;

    // Decode results of the byte in the input register.
    logic [7:0]              s_emit [4];
    logic [2:0]              s_emit_cnt;
    logic [1:0]              s_inc;
    logic                    s_raw_go;
    logic [4:0]              s_hex;
    logic [8:0]              s_ctl;
    logic [3:0]              s_dl;
    logic [2:0]              s_num;
    logic [COUNT_WIDTH:0]    s_sum;
    logic [COUNT_WIDTH+31:0] s_ext;
    logic [31:0]             s_count32;

    // Handshake control.
    logic s_last_beat;
    logic s_out_fire;
    logic s_move;
    logic s_in_fire;

    assign s_last_beat = r_busy && ({1'b0, r_ptr} == (r_num - 3'd1));
    assign s_out_fire  = r_busy && i_ready;
    assign s_move      = r_in_valid && (!r_busy || (i_ready && s_last_beat));
    assign o_ready     = !r_in_valid || s_move;
    assign s_in_fire   = i_valid && o_ready;

    // Decode one source byte against the current state.
    always_comb begin
        n_mode     = r_mode;
        n_digits   = r_digits;
        n_acc      = r_acc;
        n_utf8     = r_utf8;
        n_kind     = r_kind;
        n_err      = r_err;
        s_emit[0]  = 8'h00;
        s_emit[1]  = 8'h00;
        s_emit[2]  = 8'h00;
        s_emit[3]  = 8'h00;
        s_emit_cnt = 3'd0;
        s_inc      = 2'd0;
        s_raw_go   = 1'b0;
        s_hex      = esc_utf8_pkg::hex_value(r_in_byte);
        s_ctl      = esc_utf8_pkg::esc_control(r_in_byte);
        s_dl       = 4'd0;

        if (r_err == esc_utf8_pkg::ERR_NONE) begin
            unique case (r_mode)
                esc_utf8_pkg::M_NORMAL: begin
                    if (r_utf8 == 2'd0 && r_in_byte == esc_utf8_pkg::CH_BSLASH) begin
                        if (r_in_last) begin
                            // A trailing backslash is kept as it is.
                            s_emit[s_emit_cnt[1:0]] = esc_utf8_pkg::CH_BSLASH;
                            s_emit_cnt = s_emit_cnt + 3'd1;
                            s_inc = s_inc + 2'd1;
                        end else begin
                            n_mode = esc_utf8_pkg::M_ESC;
                        end
                    end else begin
                        s_raw_go = 1'b1;
                    end
                end
                esc_utf8_pkg::M_ESC: begin
                    n_mode = esc_utf8_pkg::M_NORMAL;
                    if (s_ctl[8]) begin
                        s_emit[s_emit_cnt[1:0]] = s_ctl[7:0];
                        s_emit_cnt = s_emit_cnt + 3'd1;
                        s_inc = s_inc + 2'd1;
                    end else if (r_in_byte == esc_utf8_pkg::CH_LOW_X) begin
                        n_mode   = esc_utf8_pkg::M_HEX_X;
                        n_digits = 4'd2;
                        n_acc    = 32'h0;
                    end else if (r_in_byte == esc_utf8_pkg::CH_LOW_U) begin
                        n_mode   = esc_utf8_pkg::M_HEX_U4;
                        n_digits = 4'd4;
                        n_acc    = 32'h0;
                    end else if (r_in_byte == esc_utf8_pkg::CH_UP_U) begin
                        n_mode   = esc_utf8_pkg::M_HEX_U8;
                        n_digits = 4'd8;
                        n_acc    = 32'h0;
                    end else begin
                        // Unknown escape: the backslash, then the character as raw.
                        s_emit[s_emit_cnt[1:0]] = esc_utf8_pkg::CH_BSLASH;
                        s_emit_cnt = s_emit_cnt + 3'd1;
                        s_inc = s_inc + 2'd1;
                        s_raw_go = 1'b1;
                    end
                end
                esc_utf8_pkg::M_HEX_X, esc_utf8_pkg::M_HEX_U4, esc_utf8_pkg::M_HEX_U8: begin
                    if (s_hex[4]) begin
                        n_err = (r_mode == esc_utf8_pkg::M_HEX_X) ?
                                esc_utf8_pkg::ERR_BAD_HEX : esc_utf8_pkg::ERR_BAD_UNI;
                    end else begin
                        n_acc    = {r_acc[27:0], s_hex[3:0]};
                        s_dl     = (r_digits == 4'd0) ? 4'd0 : r_digits - 4'd1;
                        n_digits = s_dl;
                        if (s_dl == 4'd0) begin
                            n_mode = esc_utf8_pkg::M_NORMAL;
                            if (r_mode == esc_utf8_pkg::M_HEX_X) begin
                                // A hex byte goes out unchecked.
                                s_emit[s_emit_cnt[1:0]] = n_acc[7:0];
                                s_emit_cnt = s_emit_cnt + 3'd1;
                                s_inc = s_inc + 2'd1;
                            end else if (n_acc >= esc_utf8_pkg::CP_LIMIT) begin
                                n_err = esc_utf8_pkg::ERR_CP_RANGE;
                            end else begin
                                // UTF-8 encoding of the code point.
                                if (n_acc < 32'h80) begin
                                    s_emit[0]  = n_acc[7:0];
                                    s_emit_cnt = 3'd1;
                                end else if (n_acc < 32'h800) begin
                                    s_emit[0]  = {3'b110, n_acc[10:6]};
                                    s_emit[1]  = {2'b10, n_acc[5:0]};
                                    s_emit_cnt = 3'd2;
                                    if (esc_utf8_pkg::KIND_TWO > n_kind) begin
                                        n_kind = esc_utf8_pkg::KIND_TWO;
                                    end
                                end else if (n_acc < 32'h1_0000) begin
                                    s_emit[0]  = {4'b1110, n_acc[15:12]};
                                    s_emit[1]  = {2'b10, n_acc[11:6]};
                                    s_emit[2]  = {2'b10, n_acc[5:0]};
                                    s_emit_cnt = 3'd3;
                                    if (esc_utf8_pkg::KIND_THREE > n_kind) begin
                                        n_kind = esc_utf8_pkg::KIND_THREE;
                                    end
                                end else begin
                                    s_emit[0]  = {5'b11110, n_acc[20:18]};
                                    s_emit[1]  = {2'b10, n_acc[17:12]};
                                    s_emit[2]  = {2'b10, n_acc[11:6]};
                                    s_emit[3]  = {2'b10, n_acc[5:0]};
                                    s_emit_cnt = 3'd4;
                                    n_kind     = esc_utf8_pkg::KIND_FOUR;
                                end
                                s_inc = s_inc + 2'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_mode = esc_utf8_pkg::M_NORMAL;
                end
            endcase

            // UTF-8 check of a raw byte.
            if (s_raw_go) begin
                if (n_utf8 == 2'd0) begin
                    if (!r_in_byte[7]) begin
                        s_emit[s_emit_cnt[1:0]] = r_in_byte;
                        s_emit_cnt = s_emit_cnt + 3'd1;
                        s_inc = s_inc + 2'd1;
                    end else if (r_in_byte[7:5] == 3'b110) begin
                        if (esc_utf8_pkg::KIND_TWO > n_kind) begin
                            n_kind = esc_utf8_pkg::KIND_TWO;
                        end
                        n_utf8 = 2'd1;
                        s_emit[s_emit_cnt[1:0]] = r_in_byte;
                        s_emit_cnt = s_emit_cnt + 3'd1;
                    end else if (r_in_byte[7:4] == 4'b1110) begin
                        if (esc_utf8_pkg::KIND_THREE > n_kind) begin
                            n_kind = esc_utf8_pkg::KIND_THREE;
                        end
                        n_utf8 = 2'd2;
                        s_emit[s_emit_cnt[1:0]] = r_in_byte;
                        s_emit_cnt = s_emit_cnt + 3'd1;
                    end else if (r_in_byte[7:3] == 5'b11110) begin
                        n_kind = esc_utf8_pkg::KIND_FOUR;
                        n_utf8 = 2'd3;
                        s_emit[s_emit_cnt[1:0]] = r_in_byte;
                        s_emit_cnt = s_emit_cnt + 3'd1;
                    end else begin
                        n_err = esc_utf8_pkg::ERR_BAD_START;
                    end
                end else if (r_in_byte[7:6] == 2'b10) begin
                    s_emit[s_emit_cnt[1:0]] = r_in_byte;
                    s_emit_cnt = s_emit_cnt + 3'd1;
                    n_utf8 = n_utf8 - 2'd1;
                    if (n_utf8 == 2'd0) begin
                        s_inc = s_inc + 2'd1;
                    end
                end else begin
                    n_err = esc_utf8_pkg::ERR_BAD_CONT;
                end
            end

            // A string that ends inside an escape or a UTF-8 sequence.
            if (r_in_last && n_err == esc_utf8_pkg::ERR_NONE) begin
                if (n_mode == esc_utf8_pkg::M_HEX_X) begin
                    n_err = esc_utf8_pkg::ERR_TRUNC_HEX;
                end else if (n_mode != esc_utf8_pkg::M_NORMAL) begin
                    n_err = esc_utf8_pkg::ERR_BAD_UNI;
                end else if (n_utf8 != 2'd0) begin
                    n_err = esc_utf8_pkg::ERR_BAD_CONT;
                end
            end

            // An erroring byte outputs nothing.
            if (n_err != esc_utf8_pkg::ERR_NONE) begin
                s_emit_cnt = 3'd0;
            end
        end

        // Saturating code point count.
        s_sum   = {1'b0, r_count} + (COUNT_WIDTH + 1)'(s_inc);
        n_count = s_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s_sum[COUNT_WIDTH-1:0];

        // Count as reported on the 32-bit output.
        s_ext     = {32'h0, n_count};
        s_count32 = (|s_ext[COUNT_WIDTH+31:32]) ? 32'hFFFF_FFFF : s_ext[31:0];

        // The final byte always yields at least the summary result.
        s_num = (r_in_last && s_emit_cnt == 3'd0) ? 3'd1 : s_emit_cnt;
    end

    // Control and decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_busy     <= 1'b0;
            r_ptr      <= 2'd0;
            r_mode     <= esc_utf8_pkg::M_NORMAL;
            r_digits   <= 4'd0;
            r_acc      <= 32'h0;
            r_utf8     <= 2'd0;
            r_kind     <= esc_utf8_pkg::KIND_ASCII;
            r_count    <= '0;
            r_err      <= esc_utf8_pkg::ERR_NONE;
        end else begin
            if (s_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s_move) begin
                r_in_valid <= 1'b0;
            end

            if (s_move) begin
                if (r_in_last) begin
                    r_mode   <= esc_utf8_pkg::M_NORMAL;
                    r_digits <= 4'd0;
                    r_acc    <= 32'h0;
                    r_utf8   <= 2'd0;
                    r_kind   <= esc_utf8_pkg::KIND_ASCII;
                    r_count  <= '0;
                    r_err    <= esc_utf8_pkg::ERR_NONE;
                end else begin
                    r_mode   <= n_mode;
                    r_digits <= n_digits;
                    r_acc    <= n_acc;
                    r_utf8   <= n_utf8;
                    r_kind   <= n_kind;
                    r_count  <= n_count;
                    r_err    <= n_err;
                end
                r_busy <= (s_num != 3'd0);
                r_ptr  <= 2'd0;
            end else if (s_out_fire) begin
                if (s_last_beat) begin
                    r_busy <= 1'b0;
                end else begin
                    r_ptr <= r_ptr + 2'd1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
        if (s_move && s_num != 3'd0) begin
            r_bytes     <= s_emit;
            r_num       <= s_num;
            r_has_bytes <= (s_emit_cnt != 3'd0);
            r_last      <= r_in_last;
            r_res_err   <= n_err;
            r_res_kind  <= n_kind;
            r_res_count <= s_count32;
        end
    end

    // Result beat selection.
    assign o_valid       = r_busy;
    assign o_out_byte    = r_has_bytes ? r_bytes[r_ptr] : 8'h00;
    assign o_byte_valid  = r_has_bytes;
    assign o_run_end     = s_last_beat;
    assign o_string_done = s_last_beat && r_last;
    assign o_error_code  = r_res_err;
    assign o_char_kind   = r_res_kind;
    assign o_char_count  = r_res_count;

endmodule

/* sv/esc_utf8_checker.sv */
// Port-level checker of the escape decoder and its bind to the top level.
`include "escape_unescaper_utf8_validator_unit_assert.svh"

module esc_utf8_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic        o_run_end,
    input logic        o_string_done,
    input logic [2:0]  o_error_code
);

    // A stalled result beat holds its byte and its run marker.
    `EUV_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte) && $stable(o_run_end))

    // The summary of a string always closes the run of its final byte.
    `EUV_ASSERT_NOW(a_done_ends_run, i_clk, i_rst_n, o_valid && o_string_done, o_run_end)

    // A beat without a byte is only ever the closing summary.
    `EUV_ASSERT_NOW(a_empty_is_summary, i_clk, i_rst_n, o_valid && !o_byte_valid, o_run_end && o_string_done)

    // Once an error is reported, no decoded byte goes out.
    `EUV_ASSERT_NOW(a_error_drops, i_clk, i_rst_n, o_valid && (o_error_code != esc_utf8_pkg::ERR_NONE), !o_byte_valid)

endmodule

bind escape_unescaper_utf8_validator_unit esc_utf8_checker u_esc_utf8_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_run_end     (o_run_end),
    .o_string_done (o_string_done),
    .o_error_code  (o_error_code)
);

/* sim/tb.sv */
// Self-checking testbench for the backslash escape decoder with UTF-8 checking.
module tb;

    // One result beat as seen on the output channel.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_end;
        logic        string_done;
        logic [2:0]  error_code;
        logic [1:0]  char_kind;
        logic [31:0] char_count;
    } t_decoded_beat;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES     = 80;
    localparam int DRAIN_CYCLES     = 20;
    localparam int REPORT_LIMIT     = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_run_end;
    logic        o_string_done;
    logic [2:0]  o_error_code;
    logic [1:0]  o_char_kind;
    logic [31:0] o_char_count;

    escape_unescaper_utf8_validator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_end     (o_run_end),
        .o_string_done (o_string_done),
        .o_error_code  (o_error_code),
        .o_char_kind   (o_char_kind),
        .o_char_count  (o_char_count)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state mirrored by the predictor.
    esc_utf8_pkg::t_mode dec_mode = esc_utf8_pkg::M_NORMAL;
    logic [3:0]  dec_digits_left = 4'd0;
    logic [31:0] dec_acc = 32'd0;
    logic [1:0]  dec_utf_left = 2'd0;
    logic [1:0]  dec_kind = esc_utf8_pkg::KIND_ASCII;
    logic [31:0] dec_count = 32'd0;
    logic [2:0]  dec_err = esc_utf8_pkg::ERR_NONE;

    logic [7:0]    decoded_bytes[$];
    t_decoded_beat predicted_beats[$];
    logic [7:0]    source_text[$];

    int fail_count = 0;
    int burst_left = 0;
    int hold_left = 0;
    int window_left = 0;
    int ready_pct = 100;
    bit long_hold_req = 1'b0;

    function automatic void put_byte(input logic [7:0] b);
        decoded_bytes.push_back(b);
    endfunction

    // The code point counter saturates at its maximum.
    function automatic void count_code_point();
        if (dec_count != 32'hFFFF_FFFF) begin
            dec_count++;
        end
    endfunction

    function automatic void raise_kind(input logic [1:0] k);
        if (k > dec_kind) begin
            dec_kind = k;
        end
    endfunction

    // Only the first error of a string is kept.
    function automatic void flag_error(input logic [2:0] e);
        if (dec_err == esc_utf8_pkg::ERR_NONE) begin
            dec_err = e;
        end
    endfunction

    // UTF-8 check of one raw byte.
    function automatic void check_raw(input logic [7:0] b);
        if (dec_utf_left == 2'd0) begin
            if (b[7] == 1'b0) begin
                put_byte(b);
                count_code_point();
            end else if (b[7:5] == 3'b110) begin
                raise_kind(esc_utf8_pkg::KIND_TWO);
                dec_utf_left = 2'd1;
                put_byte(b);
            end else if (b[7:4] == 4'b1110) begin
                raise_kind(esc_utf8_pkg::KIND_THREE);
                dec_utf_left = 2'd2;
                put_byte(b);
            end else if (b[7:3] == 5'b11110) begin
                raise_kind(esc_utf8_pkg::KIND_FOUR);
                dec_utf_left = 2'd3;
                put_byte(b);
            end else begin
                flag_error(esc_utf8_pkg::ERR_BAD_START);
            end
        end else if (b[7:6] == 2'b10) begin
            put_byte(b);
            dec_utf_left--;
            if (dec_utf_left == 2'd0) begin
                count_code_point();
            end
        end else begin
            flag_error(esc_utf8_pkg::ERR_BAD_CONT);
        end
    endfunction

    // Works out the result beats of one accepted source byte.
    function automatic void decode_source_byte(input logic [7:0] b, input logic last);
        logic [4:0]          nib;
        logic [31:0]         cp;
        esc_utf8_pkg::t_mode was;
        t_decoded_beat       r;
        int                  n;
        decoded_bytes.delete();
        if (dec_err == esc_utf8_pkg::ERR_NONE) begin
            case (dec_mode)
                esc_utf8_pkg::M_NORMAL: begin
                    if (dec_utf_left == 2'd0 && b == esc_utf8_pkg::CH_BSLASH) begin
                        if (last) begin
                            put_byte(esc_utf8_pkg::CH_BSLASH);
                            count_code_point();
                        end else begin
                            dec_mode = esc_utf8_pkg::M_ESC;
                        end
                    end else begin
                        check_raw(b);
                    end
                end
                esc_utf8_pkg::M_ESC: begin
                    dec_mode = esc_utf8_pkg::M_NORMAL;
                    case (b)
                        esc_utf8_pkg::CH_LOW_A: begin
                            put_byte(esc_utf8_pkg::CTL_BEL); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_B: begin
                            put_byte(esc_utf8_pkg::CTL_BS); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_F: begin
                            put_byte(esc_utf8_pkg::CTL_FF); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_N: begin
                            put_byte(esc_utf8_pkg::CTL_LF); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_R: begin
                            put_byte(esc_utf8_pkg::CTL_CR); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_T: begin
                            put_byte(esc_utf8_pkg::CTL_HT); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_V: begin
                            put_byte(esc_utf8_pkg::CTL_VT); count_code_point();
                        end
                        esc_utf8_pkg::CH_BSLASH: begin
                            put_byte(esc_utf8_pkg::CH_BSLASH); count_code_point();
                        end
                        esc_utf8_pkg::CH_LOW_X: begin
                            dec_mode = esc_utf8_pkg::M_HEX_X;
                            dec_digits_left = 4'd2;
                            dec_acc = 32'd0;
                        end
                        esc_utf8_pkg::CH_LOW_U: begin
                            dec_mode = esc_utf8_pkg::M_HEX_U4;
                            dec_digits_left = 4'd4;
                            dec_acc = 32'd0;
                        end
                        esc_utf8_pkg::CH_UP_U: begin
                            dec_mode = esc_utf8_pkg::M_HEX_U8;
                            dec_digits_left = 4'd8;
                            dec_acc = 32'd0;
                        end
                        default: begin
                            // Unknown escape: the backslash stands, the byte is raw.
                            put_byte(esc_utf8_pkg::CH_BSLASH);
                            count_code_point();
                            check_raw(b);
                        end
                    endcase
                end
                default: begin
                    // Collecting hex digits.
                    if (b >= "0" && b <= "9") begin
                        nib = {1'b0, 4'(b - "0")};
                    end else if (b >= "a" && b <= "f") begin
                        nib = {1'b0, 4'(b - "a" + 8'd10)};
                    end else if (b >= "A" && b <= "F") begin
                        nib = {1'b0, 4'(b - "A" + 8'd10)};
                    end else begin
                        nib = 5'h10;
                    end
                    if (nib[4]) begin
                        flag_error((dec_mode == esc_utf8_pkg::M_HEX_X) ?
                                   esc_utf8_pkg::ERR_BAD_HEX : esc_utf8_pkg::ERR_BAD_UNI);
                    end else begin
                        dec_acc = {dec_acc[27:0], nib[3:0]};
                        if (dec_digits_left != 4'd0) begin
                            dec_digits_left--;
                        end
                        if (dec_digits_left == 4'd0) begin
                            was = dec_mode;
                            dec_mode = esc_utf8_pkg::M_NORMAL;
                            cp = dec_acc;
                            if (was == esc_utf8_pkg::M_HEX_X) begin
                                put_byte(cp[7:0]);
                                count_code_point();
                            end else if (cp >= esc_utf8_pkg::CP_LIMIT) begin
                                flag_error(esc_utf8_pkg::ERR_CP_RANGE);
                            end else begin
                                // UTF-8 encoding of the code point.
                                if (cp < 32'h80) begin
                                    put_byte(cp[7:0]);
                                end else if (cp < 32'h800) begin
                                    put_byte({3'b110, cp[10:6]});
                                    put_byte({2'b10, cp[5:0]});
                                    raise_kind(esc_utf8_pkg::KIND_TWO);
                                end else if (cp < 32'h10000) begin
                                    put_byte({4'b1110, cp[15:12]});
                                    put_byte({2'b10, cp[11:6]});
                                    put_byte({2'b10, cp[5:0]});
                                    raise_kind(esc_utf8_pkg::KIND_THREE);
                                end else begin
                                    put_byte({5'b11110, cp[20:18]});
                                    put_byte({2'b10, cp[17:12]});
                                    put_byte({2'b10, cp[11:6]});
                                    put_byte({2'b10, cp[5:0]});
                                    raise_kind(esc_utf8_pkg::KIND_FOUR);
                                end
                                count_code_point();
                            end
                        end
                    end
                end
            endcase
            // A string may not end inside an escape or a UTF-8 sequence.
            if (last && dec_err == esc_utf8_pkg::ERR_NONE) begin
                if (dec_mode == esc_utf8_pkg::M_HEX_X) begin
                    flag_error(esc_utf8_pkg::ERR_TRUNC_HEX);
                end else if (dec_mode != esc_utf8_pkg::M_NORMAL) begin
                    flag_error(esc_utf8_pkg::ERR_BAD_UNI);
                end else if (dec_utf_left != 2'd0) begin
                    flag_error(esc_utf8_pkg::ERR_BAD_CONT);
                end
            end
            if (dec_err != esc_utf8_pkg::ERR_NONE) begin
                decoded_bytes.delete();
            end
        end

        n = decoded_bytes.size();
        if (last && n == 0) begin
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            r.out_byte    = (k < decoded_bytes.size()) ? decoded_bytes[k] : 8'h00;
            r.byte_valid  = (k < decoded_bytes.size());
            r.run_end     = (k == n - 1);
            r.string_done = (k == n - 1) && last;
            r.error_code  = dec_err;
            r.char_kind   = dec_kind;
            r.char_count  = dec_count;
            predicted_beats.push_back(r);
        end

        // The summary returns the decoder to its reset state.
        if (last) begin
            dec_mode = esc_utf8_pkg::M_NORMAL;
            dec_digits_left = 4'd0;
            dec_acc = 32'd0;
            dec_utf_left = 2'd0;
            dec_kind = esc_utf8_pkg::KIND_ASCII;
            dec_count = 32'd0;
            dec_err = esc_utf8_pkg::ERR_NONE;
        end
    endfunction

    function automatic string beat_text(input t_decoded_beat b);
        return $sformatf("byte=%h bv=%b end=%b done=%b err=%0d kind=%0d count=%0d",
                         b.out_byte, b.byte_valid, b.run_end, b.string_done,
                         b.error_code, b.char_kind, b.char_count);
    endfunction

    // Checks every accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_decoded_beat want;
        t_decoded_beat got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_out_byte, o_byte_valid, o_run_end, o_string_done,
                   o_error_code, o_char_kind, o_char_count};
            if (predicted_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected beat: %s", beat_text(got));
                end
            end else begin
                want = predicted_beats.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.run_end !== want.run_end || got.string_done !== want.string_done ||
                    got.error_code !== want.error_code ||
                    got.char_kind !== want.char_kind ||
                    got.char_count !== want.char_count) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("beat mismatch: expected %s", beat_text(want));
                        $display("               actual   %s", beat_text(got));
                    end
                end
            end
        end
    end

    // Receiver: windows of random readiness, plus one long hold on request.
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (window_left == 0) begin
            window_left = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                default: ready_pct = 20;
            endcase
        end
        window_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Offers one source byte and waits until it is accepted; the sender idles between bursts.
    task automatic send_byte(input logic [7:0] value, input logic last);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_in_byte   <= value;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        decode_source_byte(value, last);
    endtask

    task automatic send_source_text();
        for (int i = 0; i < source_text.size(); i++) begin
            send_byte(source_text[i], i == source_text.size() - 1);
        end
        source_text.delete();
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            source_text.push_back(s[i]);
        end
    endfunction

    // Appends hex digits of a value, most significant first, in mixed case.
    function automatic void push_hex(input logic [31:0] val, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = val[4*i +: 4];
            if (nib < 4'd10) begin
                source_text.push_back(8'h30 + 8'(nib));
            end else if ($urandom_range(0, 1) == 1) begin
                source_text.push_back(8'h61 + 8'(nib) - 8'd10);
            end else begin
                source_text.push_back(8'h41 + 8'(nib) - 8'd10);
            end
        end
    endfunction

    // Builds one string from random tokens; a dirty string mixes in broken ones.
    function automatic void build_random_string(input bit clean);
        int         tokens;
        bit         good;
        bit         special;
        logic [7:0] ch;
        tokens = $urandom_range(1, 10);
        repeat (tokens) begin
            good = clean || ($urandom_range(0, 2) != 0);
            if (good) begin
                case ($urandom_range(0, 8))
                    0: begin
                        do ch = 8'($urandom_range(0, 127));
                        while (ch == esc_utf8_pkg::CH_BSLASH);
                        source_text.push_back(ch);
                    end
                    1: begin
                        case ($urandom_range(0, 7))
                            0: ch = esc_utf8_pkg::CH_LOW_A;
                            1: ch = esc_utf8_pkg::CH_LOW_B;
                            2: ch = esc_utf8_pkg::CH_LOW_F;
                            3: ch = esc_utf8_pkg::CH_LOW_N;
                            4: ch = esc_utf8_pkg::CH_LOW_R;
                            5: ch = esc_utf8_pkg::CH_LOW_T;
                            6: ch = esc_utf8_pkg::CH_LOW_V;
                            default: ch = esc_utf8_pkg::CH_BSLASH;
                        endcase
                        source_text.push_back(esc_utf8_pkg::CH_BSLASH);
                        source_text.push_back(ch);
                    end
                    2: begin
                        push_text("\\x");
                        push_hex($urandom_range(0, 255), 2);
                    end
                    3: begin
                        push_text("\\u");
                        push_hex($urandom_range(0, 32'hFFFF), 4);
                    end
                    4: begin
                        push_text("\\U");
                        push_hex($urandom_range(0, 32'h10FFFF), 8);
                    end
                    5: begin
                        source_text.push_back({3'b110, 5'($urandom)});
                        source_text.push_back({2'b10, 6'($urandom)});
                    end
                    6: begin
                        source_text.push_back({4'b1110, 4'($urandom)});
                        repeat (2) source_text.push_back({2'b10, 6'($urandom)});
                    end
                    7: begin
                        source_text.push_back({5'b11110, 3'($urandom)});
                        repeat (3) source_text.push_back({2'b10, 6'($urandom)});
                    end
                    default: begin
                        // Escape of a character with no meaning.
                        do begin
                            ch = 8'($urandom_range(0, 127));
                            case (ch)
                                esc_utf8_pkg::CH_LOW_A, esc_utf8_pkg::CH_LOW_B,
                                esc_utf8_pkg::CH_LOW_F, esc_utf8_pkg::CH_LOW_N,
                                esc_utf8_pkg::CH_LOW_R, esc_utf8_pkg::CH_LOW_T,
                                esc_utf8_pkg::CH_LOW_V, esc_utf8_pkg::CH_LOW_X,
                                esc_utf8_pkg::CH_LOW_U, esc_utf8_pkg::CH_UP_U,
                                esc_utf8_pkg::CH_BSLASH: special = 1'b1;
                                default:                 special = 1'b0;
                            endcase
                        end while (special);
                        source_text.push_back(esc_utf8_pkg::CH_BSLASH);
                        source_text.push_back(ch);
                    end
                endcase
            end else begin
                case ($urandom_range(0, 5))
                    0: source_text.push_back(8'($urandom_range(0, 255)));
                    1: begin
                        push_text("\\x");
                        push_hex($urandom, 1);
                        source_text.push_back(8'h67 + 8'($urandom_range(0, 19)));
                    end
                    2: begin
                        push_text("\\U");
                        push_hex($urandom_range(32'h110000, 32'hFFFF_FFFF), 8);
                    end
                    3: begin
                        if ($urandom_range(0, 1) == 1) begin
                            source_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
                        end else begin
                            source_text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                        end
                    end
                    4: begin
                        source_text.push_back({4'b1110, 4'($urandom)});
                        push_text("A");
                    end
                    default: begin
                        push_text("\\u");
                        push_hex($urandom, 2);
                        source_text.push_back(8'h67 + 8'($urandom_range(0, 19)));
                    end
                endcase
            end
        end
        // Strings that stop inside an escape, or with a lone backslash.
        if (clean && $urandom_range(0, 7) == 0) begin
            push_text("\\");
        end else if (!clean && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0: push_text("\\");
                1: begin push_text("\\x"); push_hex($urandom, $urandom_range(0, 1)); end
                2: begin push_text("\\u"); push_hex($urandom, $urandom_range(0, 3)); end
                default: begin push_text("\\U"); push_hex($urandom, $urandom_range(0, 7)); end
            endcase
        end
    endfunction

    // Every simple escape, an escaped backslash, an unknown escape, a zero byte.
    task automatic test_control_escapes();
        source_text.push_back(8'h00);
        push_text("\\a\\b\\f\\n\\r\\t\\v\\\\\\q");
        send_source_text();
    endtask

    // Hex byte at its top value, two-byte escape, raw four-byte at the top
    // code point, and a trailing backslash.
    task automatic test_hex_and_utf8();
        push_text("\\xFf\\u07FF");
        source_text.push_back(8'hF4);
        source_text.push_back(8'h8F);
        source_text.push_back(8'hBF);
        source_text.push_back(8'hBF);
        source_text.push_back(8'h7F);
        push_text("\\");
        send_source_text();
    endtask

    // At least one string per error code.
    task automatic test_error_cases();
        push_text("\\U00110000");
        send_source_text();
        push_text("\\x4");
        send_source_text();
        push_text("\\xgA");
        send_source_text();
        push_text("\\uZ");
        send_source_text();
        source_text.push_back(8'hFF);
        send_source_text();
        // Backslash where a continuation byte is due.
        source_text.push_back(8'hC3);
        push_text("\\");
        send_source_text();
        // String that ends inside a three-byte sequence.
        source_text.push_back(8'hE2);
        source_text.push_back(8'h82);
        send_source_text();
    endtask

    // The receiver stops for a long stretch while strings keep coming.
    task automatic test_receiver_hold();
        long_hold_req = 1'b1;
        repeat (3) begin
            build_random_string(1'b1);
            send_source_text();
        end
    endtask

    task automatic test_random_strings();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_random_string($urandom_range(0, 99) < 85);
            sent += source_text.size();
            send_source_text();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_control_escapes();
        test_hex_and_utf8();
        test_error_cases();
        test_receiver_hold();
        test_random_strings();
        i_valid <= 1'b0;
        while (predicted_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
